@@ hw/rtl/dda_line_rasterizer_top_assert.svh @@
// Assertion macros for the line rasterizer checker.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef DDA_LINE_RASTERIZER_TOP_ASSERT_SVH
`define DDA_LINE_RASTERIZER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define DDA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dda assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define DDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dda assertion failed");

`endif

@@ hw/rtl/dda_pkg.sv @@
// Shared types and constants for the line rasterizer.
// No dependencies; used by the controller, the datapath, the top level and the checker.
package dda_pkg;

    localparam int COORD_BITS = 9;
    localparam int FRAC_BITS  = 16;
    localparam int POS_BITS   = COORD_BITS + FRAC_BITS;
    localparam int QUOT_BITS  = FRAC_BITS + 1;
    localparam int REM_BITS   = COORD_BITS + 1;
    localparam int DIV_STEPS  = FRAC_BITS + 1;
    localparam int DCNT_BITS  = $clog2(DIV_STEPS);

    localparam logic [FRAC_BITS-1:0] FRAC_HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef struct packed {
        logic load;
        logic div;
        logic tick;
    } t_dp_cmd;

    typedef struct packed {
        logic steps_zero;
        logic div_done;
        logic last_step;
        logic out_busy;
    } t_dp_status;

endpackage

@@ hw/rtl/dda_ctrl.sv @@
// Line rasterizer controller: idle / divide / active sequencing and input flow control.
// Depends on dda_pkg; drives the datapath through t_dp_cmd, reads t_dp_status.
module dda_ctrl import dda_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_command,
    output logic       o_in_stall,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ACTIVE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    always_comb begin
        o_in_stall = (r_state == ST_DIV) || i_status.out_busy;
        accept     = i_in_valid && !o_in_stall;

        o_cmd.load = accept && (i_command == CMD_START);
        o_cmd.tick = accept && (i_command == CMD_TICK) && (r_state == ST_ACTIVE);
        o_cmd.div  = (r_state == ST_DIV);

        n_state = r_state;
        if (o_cmd.load) begin
            // a new request drops any line in progress
            n_state = i_status.steps_zero ? ST_IDLE : ST_DIV;
        end else begin
            case (r_state)
                ST_DIV: begin
                    if (i_status.div_done) begin
                        n_state = ST_ACTIVE;
                    end
                end
                ST_ACTIVE: begin
                    if (o_cmd.tick && i_status.last_step) begin
                        n_state = ST_IDLE;
                    end
                end
                default: begin
                    n_state = r_state;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hw/rtl/dda_datapath.sv @@
// Line rasterizer datapath: endpoint setup, bit-serial increment division,
// position accumulators and the output register. Depends on dda_pkg.
module dda_datapath import dda_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last_pixel
);

    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic [COORD_BITS-1:0] steps;
    logic                  neg_x;
    logic                  neg_y;

    logic [COORD_BITS-1:0] r_steps;
    logic [COORD_BITS-1:0] r_steps_left;
    logic [REM_BITS-1:0]   r_rem_x;
    logic [REM_BITS-1:0]   r_rem_y;
    logic [QUOT_BITS-1:0]  r_q_x;
    logic [QUOT_BITS-1:0]  r_q_y;
    logic                  r_neg_x;
    logic                  r_neg_y;
    logic [DCNT_BITS-1:0]  r_div_cnt;
    // positions are kept biased by one half so the pixel is a plain bit-select
    logic [POS_BITS-1:0]   r_pos_x;
    logic [POS_BITS-1:0]   r_pos_y;

    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_pixel_x;
    logic [COORD_BITS-1:0] r_pixel_y;
    logic                  r_last_pixel;

    logic [REM_BITS-1:0]   div_ref;
    logic                  ge_x;
    logic                  ge_y;
    logic [REM_BITS-1:0]   rem_sel_x;
    logic [REM_BITS-1:0]   rem_sel_y;
    logic [POS_BITS-1:0]   pos_next_x;
    logic [POS_BITS-1:0]   pos_next_y;

    always_comb begin
        neg_x = i_x_end < i_x_start;
        neg_y = i_y_end < i_y_start;
        adx   = neg_x ? (i_x_start - i_x_end) : (i_x_end - i_x_start);
        ady   = neg_y ? (i_y_start - i_y_end) : (i_y_end - i_y_start);
        steps = (adx > ady) ? adx : ady;

        div_ref   = {1'b0, r_steps};
        ge_x      = r_rem_x >= div_ref;
        ge_y      = r_rem_y >= div_ref;
        rem_sel_x = ge_x ? (r_rem_x - div_ref) : r_rem_x;
        rem_sel_y = ge_y ? (r_rem_y - div_ref) : r_rem_y;

        pos_next_x = r_neg_x ? (r_pos_x - POS_BITS'(r_q_x)) : (r_pos_x + POS_BITS'(r_q_x));
        pos_next_y = r_neg_y ? (r_pos_y - POS_BITS'(r_q_y)) : (r_pos_y + POS_BITS'(r_q_y));

        o_status.steps_zero = (steps == '0);
        o_status.div_done   = (r_div_cnt == DCNT_BITS'(DIV_STEPS - 1));
        o_status.last_step  = (r_steps_left == COORD_BITS'(1));
        o_status.out_busy   = r_out_valid && i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_steps      <= steps;
            r_steps_left <= steps;
            r_rem_x      <= {1'b0, adx};
            r_rem_y      <= {1'b0, ady};
            r_q_x        <= '0;
            r_q_y        <= '0;
            r_neg_x      <= neg_x;
            r_neg_y      <= neg_y;
            r_pos_x      <= {i_x_start, FRAC_HALF};
            r_pos_y      <= {i_y_start, FRAC_HALF};
        end else if (i_cmd.div) begin
            // one quotient bit per cycle, integer bit first
            r_rem_x <= {rem_sel_x[REM_BITS-2:0], 1'b0};
            r_rem_y <= {rem_sel_y[REM_BITS-2:0], 1'b0};
            r_q_x   <= {r_q_x[QUOT_BITS-2:0], ge_x};
            r_q_y   <= {r_q_y[QUOT_BITS-2:0], ge_y};
        end else if (i_cmd.tick) begin
            r_pos_x      <= pos_next_x;
            r_pos_y      <= pos_next_y;
            r_steps_left <= r_steps_left - COORD_BITS'(1);
        end

        if (i_cmd.load) begin
            r_pixel_x    <= i_x_start;
            r_pixel_y    <= i_y_start;
            r_last_pixel <= o_status.steps_zero;
        end else if (i_cmd.tick) begin
            r_pixel_x    <= pos_next_x[POS_BITS-1:FRAC_BITS];
            r_pixel_y    <= pos_next_y[POS_BITS-1:FRAC_BITS];
            r_last_pixel <= o_status.last_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div) begin
                r_div_cnt <= r_div_cnt + DCNT_BITS'(1);
            end

            if (i_cmd.load || i_cmd.tick) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_x    = r_pixel_x;
    assign o_pixel_y    = r_pixel_y;
    assign o_last_pixel = r_last_pixel;

endmodule

@@ hw/rtl/dda_line_rasterizer_top.sv @@
// Line rasterizer top level: controller plus datapath.
// Depends on dda_pkg, dda_ctrl and dda_datapath.
//
// A start request (command 0) presents the start point on the output at once,
// then holds o_in_stall high while a bit-serial restoring divider forms both
// per-axis increments, one quotient bit per cycle. After that every step tick
// (command 1) yields one pixel per cycle, rounded half up, while the output is
// not stalled, the last one flagged with o_last_pixel. Coincident
// endpoints give the start point alone, flagged last, with no divide. Ticks
// with no line in progress are taken and dropped. A start during a line
// drops that line. Input is stalled while a result waits on a stalled output.
module dda_line_rasterizer_top import dda_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_command,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last_pixel
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    dda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd),
        .i_status   (dp_status)
    );

    dda_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .i_x_start    (i_x_start),
        .i_y_start    (i_y_start),
        .i_x_end      (i_x_end),
        .i_y_end      (i_y_end),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_last_pixel (o_last_pixel)
    );

endmodule

@@ hw/rtl/dda_chk.sv @@
// Port-level checker for the line rasterizer, bound to the top level.
// Depends on dda_pkg and dda_line_rasterizer_top_assert.svh.
`include "dda_line_rasterizer_top_assert.svh"

module dda_chk import dda_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  i_command,
    input logic [COORD_BITS-1:0] i_x_start,
    input logic [COORD_BITS-1:0] i_y_start,
    input logic [COORD_BITS-1:0] i_x_end,
    input logic [COORD_BITS-1:0] i_y_end,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [COORD_BITS-1:0] o_pixel_x,
    input logic [COORD_BITS-1:0] o_pixel_y,
    input logic                  o_last_pixel
);

    logic                    start_acc;
    logic                    same_pts;
    logic                    out_held;
    logic [2*COORD_BITS-1:0] start_pt;
    logic [2*COORD_BITS-1:0] out_pt;

    assign start_acc = i_in_valid && !o_in_stall && (i_command == CMD_START);
    assign same_pts  = (i_x_start == i_x_end) && (i_y_start == i_y_end);
    assign out_held  = o_out_valid && i_out_stall;
    assign start_pt  = {i_x_start, i_y_start};
    assign out_pt    = {o_pixel_x, o_pixel_y};

    `DDA_ASSERT_NEXT(a_out_hold, out_held, o_out_valid)
    `DDA_ASSERT_NEXT(a_out_stable, out_held, $stable({out_pt, o_last_pixel}))
    `DDA_ASSERT_NEXT(a_start_pixel, start_acc, o_out_valid && (out_pt == $past(start_pt)))
    `DDA_ASSERT_NEXT(a_point_last, start_acc && same_pts, o_last_pixel)
    `DDA_ASSERT_NEXT(a_line_divides, start_acc && !same_pts, o_in_stall && !o_last_pixel)

endmodule

bind dda_line_rasterizer_top dda_chk u_chk (.*);
